>>> sv/smat_pkg.sv
// Shared types and constants for the square matrix add/sub/multiply block.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package smat_pkg;

  // Default largest matrix dimension
  localparam int MAX_DIM_DEF = 8;

  // Field widths
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 3;
  localparam int DIM_W      = 4;
  localparam int MODE_W     = 2;
  localparam int COUNT_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE   = 1'b1;

  // Dimension after reset
  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // Operation codes
  typedef enum logic [MODE_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  // Command from controller to datapath
  typedef struct packed {
    logic             wr_a;     // write element into the A store
    logic             wr_b;     // write element into the B store
    logic             rd;       // read one operand pair
    logic             first;    // first operand pair of a result element
    logic             last_k;   // last operand pair of a result element
    logic             last_el;  // result element is the last of the matrix
    op_t              op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } cmd_t;

endpackage

>>> sv/smat_ifs.sv
// Valid/ready channel interfaces: element feed, result stream, configuration writes.
// Depends on smat_pkg for field widths.
`timescale 1ns / 1ps

interface smat_feed_if;
  import smat_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element;
  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface smat_res_if;
  import smat_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic                     last;
  modport source (output valid, output value, output row, output col, output last,
                  input ready);
  modport sink   (input valid, input value, input row, input col, input last,
                  output ready);
endinterface

interface smat_cfg_if;
  import smat_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/square_matrix_add_sub_multiply.sv
// Top level of the square matrix add/sub/multiply block.
// Depends on smat_pkg, the channel interfaces, smat_ctrl and smat_dpath.
`timescale 1ns / 1ps

// Usage:
//   cfg    : register writes (index 0 dimension n, index 1 mode: 0 A+B, 1 A-B,
//            2 or 3 A*B), always ready. Write only while no result is pending.
//   feed   : matrix elements, A then B, row-major, n*n each. One transfer per
//            cycle while loading; ready drops after the last element of B
//            until the result matrix has been computed.
//   result : n*n result elements in row-major order with row, col, and last
//            set on the final one.
// Sequencing: each result element is produced by one pass over the single
//   read port of each store and the one multiplier, reading n operand pairs
//   for the product and one for sum and difference. Operand reads for the
//   next element start only after the current one has been handed to the
//   output register, and loading of new matrices waits until the last
//   result element has been handed off.
// Reset: dimension 8, product mode, load count zero; store contents are
//   undefined until loaded.
// Stall: a result waiting on result.ready holds in the output register, the
//   next finished element holds in the accumulator, and sequencing pauses.
//   Loading of the next matrices may start while the last result waits.

module square_matrix_add_sub_multiply #(
  parameter int MAX_DIM = smat_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  smat_feed_if.sink   feed,
  smat_res_if.source  result,
  smat_cfg_if.sink    cfg
);
  import smat_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t              cmd;
  logic              feed_ready;
  logic              res_loaded;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_a_addr;
  logic [ADDR_W-1:0] rd_b_addr;

  assign feed.ready = feed_ready;

  smat_ctrl #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .feed_valid (feed.valid),
    .feed_ready (feed_ready),
    .res_loaded (res_loaded),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_a_addr  (rd_a_addr),
    .rd_b_addr  (rd_b_addr)
  );

  smat_dpath #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_a_addr  (rd_a_addr),
    .rd_b_addr  (rd_b_addr),
    .wr_data    (feed.element),
    .res_loaded (res_loaded),
    .result     (result)
  );

`ifndef SYNTHESIS
  // No element is taken while operands are being read
  a_rd_no_feed: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> !feed_ready)
    else $error("feed ready during operand read");

  // After the last operand pair the controller waits for the hand-off
  a_issue_gap: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd && cmd.last_k) |=> !cmd.rd)
    else $error("operand read right after last pair");

  // Hand-off to the output register never overlaps a read
  a_loaded_idle: assert property (@(posedge clk) disable iff (rst)
    res_loaded |-> !cmd.rd)
    else $error("result hand-off during operand read");

  // Each transferred element lands in exactly one store
  a_one_store: assert property (@(posedge clk) disable iff (rst)
    (feed.valid && feed_ready) |-> (cmd.wr_a ^ cmd.wr_b))
    else $error("element not written to exactly one store");
`endif

endmodule

>>> sv/smat_ctrl.sv
// Controller: configuration registers, load counter, result sequencing state machine.
// Depends on smat_pkg and smat_cfg_if.
`timescale 1ns / 1ps

module smat_ctrl #(
  parameter int MAX_DIM = smat_pkg::MAX_DIM_DEF,
  parameter int ADDR_W  = 6
) (
  input  logic              clk,
  input  logic              rst,
  smat_cfg_if.sink          cfg,
  input  logic              feed_valid,
  output logic              feed_ready,
  input  logic              res_loaded,
  output smat_pkg::cmd_t    cmd,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [ADDR_W-1:0] rd_a_addr,
  output logic [ADDR_W-1:0] rd_b_addr
);
  import smat_pkg::*;

  localparam int LIN_W = 2 * DIM_W;

  state_t               state, state_next;
  logic [DIM_W-1:0]     dimension;
  logic [MODE_W-1:0]    op_mode;
  logic [COUNT_W-1:0]   load_count;
  logic [COUNT_W-1:0]   lc_eff;
  logic [COUNT_W-1:0]   lc_inc;
  logic [COUNT_W-1:0]   two_cells;
  logic [LIN_W-1:0]     cells;
  logic [DIM_W-1:0]     n_eff;
  logic [IDX_W-1:0]     n_m1;
  logic [IDX_W-1:0]     row, col, z;
  logic [LIN_W-1:0]     a_lin, b_lin, e_lin;
  logic [COUNT_W-1:0]   b_off;
  op_t                  op;
  logic                 feed_xfer;
  logic                 in_a;
  logic                 load_done;
  logic                 is_last_k;
  logic                 is_last_el;

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RESET;
      op_mode   <= OP_MUL;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DIMENSION: dimension <= cfg.data[DIM_W-1:0];
        REG_OP_MODE:   op_mode   <= cfg.data[MODE_W-1:0];
      endcase
    end
  end

  // Clamp dimension to 1..MAX_DIM, decode mode (unused code acts as product)
  always_comb begin
    if (dimension == '0) begin
      n_eff = DIM_W'(1);
    end else if (dimension > DIM_W'(MAX_DIM)) begin
      n_eff = DIM_W'(MAX_DIM);
    end else begin
      n_eff = dimension;
    end
    unique case (op_mode)
      OP_ADD:  op = OP_ADD;
      OP_SUB:  op = OP_SUB;
      default: op = OP_MUL;
    endcase
  end

  assign n_m1      = IDX_W'(n_eff - DIM_W'(1));
  assign cells     = LIN_W'(n_eff) * LIN_W'(n_eff);
  assign two_cells = COUNT_W'({cells, 1'b0});

  // Load bookkeeping; restart the load if the count has outgrown the dimension
  assign feed_xfer = feed_valid && feed_ready;
  assign lc_eff    = (load_count >= two_cells) ? '0 : load_count;
  assign lc_inc    = lc_eff + COUNT_W'(1);
  assign load_done = (lc_inc == two_cells);
  assign in_a      = (lc_eff < COUNT_W'(cells));
  assign b_off     = lc_eff - COUNT_W'(cells);

  // Store addresses: row-major at stride n
  assign a_lin = LIN_W'(row) * LIN_W'(n_eff) + LIN_W'(z);
  assign b_lin = LIN_W'(z) * LIN_W'(n_eff) + LIN_W'(col);
  assign e_lin = LIN_W'(row) * LIN_W'(n_eff) + LIN_W'(col);

  assign is_last_k  = (op != OP_MUL) || (z == n_m1);
  assign is_last_el = (row == n_m1) && (col == n_m1);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (feed_xfer && load_done) state_next = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (is_last_k) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (res_loaded) state_next = is_last_el ? ST_LOAD : ST_ISSUE;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Outputs to datapath and feed channel
  always_comb begin
    feed_ready  = (state == ST_LOAD);
    cmd.wr_a    = feed_xfer && in_a;
    cmd.wr_b    = feed_xfer && !in_a;
    cmd.rd      = (state == ST_ISSUE);
    cmd.first   = (z == '0);
    cmd.last_k  = is_last_k;
    cmd.last_el = is_last_el;
    cmd.op      = op;
    cmd.row     = row;
    cmd.col     = col;
    wr_addr     = in_a ? ADDR_W'(lc_eff) : ADDR_W'(b_off);
    rd_a_addr   = (op == OP_MUL) ? ADDR_W'(a_lin) : ADDR_W'(e_lin);
    rd_b_addr   = (op == OP_MUL) ? ADDR_W'(b_lin) : ADDR_W'(e_lin);
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      row        <= '0;
      col        <= '0;
      z          <= '0;
    end else begin
      state <= state_next;
      if (feed_xfer) begin
        load_count <= load_done ? '0 : lc_inc;
        if (load_done) begin
          row <= '0;
          col <= '0;
          z   <= '0;
        end
      end
      // advance inner index per operand pair
      if (state == ST_ISSUE) begin
        z <= is_last_k ? '0 : z + IDX_W'(1);
      end
      // advance to the next result element once the current one is handed off
      if (state == ST_WAIT && res_loaded) begin
        if (col == n_m1) begin
          col <= '0;
          row <= is_last_el ? '0 : row + IDX_W'(1);
        end else begin
          col <= col + IDX_W'(1);
        end
      end
    end
  end

endmodule

>>> sv/smat_dpath.sv
// Datapath: A and B element stores, operand read, multiply/add stage, accumulator,
// result output register. Depends on smat_pkg and smat_res_if.
`timescale 1ns / 1ps

module smat_dpath #(
  parameter int MAX_DIM = smat_pkg::MAX_DIM_DEF,
  parameter int ADDR_W  = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  smat_pkg::cmd_t                   cmd,
  input  logic [ADDR_W-1:0]                wr_addr,
  input  logic [ADDR_W-1:0]                rd_a_addr,
  input  logic [ADDR_W-1:0]                rd_b_addr,
  input  logic signed [smat_pkg::DATA_W-1:0] wr_data,
  output logic                             res_loaded,
  smat_res_if.source                       result
);
  import smat_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];
  logic [DATA_W-1:0] a_q, b_q;
  cmd_t              s1_cmd, s2_cmd;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] acc;
  logic              acc_done;
  logic [IDX_W-1:0]  acc_row, acc_col;
  logic              acc_last;
  logic              out_valid;
  logic [DATA_W-1:0] out_value;
  logic [IDX_W-1:0]  out_row, out_col;
  logic              out_last;

  // Element stores: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (cmd.wr_a) mem_a[wr_addr] <= wr_data;
    if (cmd.wr_b) mem_b[wr_addr] <= wr_data;
    a_q <= mem_a[rd_a_addr];
    b_q <= mem_b[rd_b_addr];
  end

  // Carry command tags alongside the operands
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_cmd <= '0;
      s2_cmd <= '0;
    end else begin
      s1_cmd <= cmd;
      s2_cmd <= s1_cmd;
    end
  end

  // Operate on the operand pair
  always_ff @(posedge clk) begin
    if (s1_cmd.rd) begin
      unique case (s1_cmd.op)
        OP_ADD:  prod <= a_q + b_q;
        OP_SUB:  prod <= a_q - b_q;
        default: prod <= DATA_W'(a_q * b_q);
      endcase
    end
  end

  // Accumulate; hold the finished element until the output register frees up
  assign res_loaded = acc_done && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (s2_cmd.rd) begin
      acc <= (s2_cmd.first ? '0 : acc) + prod;
      if (s2_cmd.last_k) begin
        acc_row  <= s2_cmd.row;
        acc_col  <= s2_cmd.col;
        acc_last <= s2_cmd.last_el;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res_loaded) acc_done <= 1'b0;
      if (s2_cmd.rd && s2_cmd.last_k) acc_done <= 1'b1;
      if (res_loaded) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (res_loaded) begin
      out_value <= acc;
      out_row   <= acc_row;
      out_col   <= acc_col;
      out_last  <= acc_last;
    end
  end

  assign result.valid = out_valid;
  assign result.value = out_value;
  assign result.row   = out_row;
  assign result.col   = out_col;
  assign result.last  = out_last;

endmodule
